>>> rtl/lfdp_pkg.sv
package lfdp_pkg;

    localparam int unsigned POS_W   = 4;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned DIST_W  = 16;
    localparam int unsigned OUT_W   = 14;
    localparam int unsigned BAND_W  = 16;

    localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'h59;
    localparam logic [DIST_W-1:0] DIST_LIMIT  = 16'd13000;

    // frame position codes
    localparam logic [POS_W-1:0] POS_HUNT  = 4'd0;
    localparam logic [POS_W-1:0] POS_HDR   = 4'd1;
    localparam logic [POS_W-1:0] POS_DLOW  = 4'd2;
    localparam logic [POS_W-1:0] POS_DHIGH = 4'd3;
    localparam logic [POS_W-1:0] POS_CSUM  = 4'd8;

    typedef struct packed {
        logic              check;   // checksum byte transferred this cycle
        logic              sum_ok;
        logic [DIST_W-1:0] dist_val;
    } frame_evt_t;

endpackage

>>> rtl/lidar_frame_distance_parser.sv
// Lidar frame parser: takes one serial byte per transfer on s_rx_byte, finds the
// two 0x59 header bytes, checks the 9-byte frame's 8-bit checksum and reports the
// little-endian distance on m_distance when it is below 13000 and differs from the
// last reported value by at least the dead band (0 acts as 1). Bad frames are dropped.
// A byte is taken every cycle; the result appears in the cycle after the checksum
// byte's transfer and sits in an output register. The input stalls only when a
// checksum byte is next while the previous result has not been taken. The dead band
// resets to 1; the user writes it via cfg_we/cfg_wdata only while the block is idle.
module lidar_frame_distance_parser
    import lfdp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [BAND_W-1:0] cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_rx_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [OUT_W-1:0]  m_distance
);

    logic       at_csum;
    frame_evt_t evt;

    assign s_ready = !m_valid || !at_csum;

    lfdp_frame u_frame (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_xfer (s_valid && s_ready),
        .rx_byte   (s_rx_byte),
        .at_csum   (at_csum),
        .evt       (evt)
    );

    lfdp_report u_report (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .evt        (evt),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_distance (m_distance)
    );

endmodule

>>> rtl/lfdp_frame.sv
module lfdp_frame
    import lfdp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              byte_xfer,
    input  logic [BYTE_W-1:0] rx_byte,
    output logic              at_csum,
    output frame_evt_t        evt
);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [BYTE_W-1:0] dlow_reg, dhigh_reg;

    always_comb begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        case (pos_reg)
            POS_HUNT: begin
                if (rx_byte == HEADER_BYTE) begin
                    pos_next = POS_HDR;
                    sum_next = rx_byte;
                end
            end
            POS_HDR: begin
                if (rx_byte == HEADER_BYTE) begin
                    pos_next = POS_DLOW;
                    sum_next = sum_reg + rx_byte;
                end else begin
                    pos_next = POS_HUNT;
                    sum_next = '0;
                end
            end
            POS_CSUM: begin
                pos_next = POS_HUNT;
                sum_next = '0;
            end
            default: begin
                pos_next = pos_reg + POS_W'(1);
                sum_next = sum_reg + rx_byte;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_HUNT;
            sum_reg <= '0;
        end else if (byte_xfer) begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (byte_xfer && pos_reg == POS_DLOW) begin
            dlow_reg <= rx_byte;
        end
        if (byte_xfer && pos_reg == POS_DHIGH) begin
            dhigh_reg <= rx_byte;
        end
    end

    assign at_csum      = (pos_reg == POS_CSUM);
    assign evt.check    = byte_xfer && at_csum;
    assign evt.sum_ok   = (rx_byte == sum_reg);
    assign evt.dist_val = {dhigh_reg, dlow_reg};

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_CSUM)
        else $error("frame position out of range");

    a_hunt_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (pos_reg == POS_HUNT) |-> (sum_reg == '0))
        else $error("running sum not cleared while hunting");

endmodule

>>> rtl/lfdp_report.sv
module lfdp_report
    import lfdp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [BAND_W-1:0] cfg_wdata,
    input  frame_evt_t        evt,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [OUT_W-1:0]  m_distance
);

    logic [BAND_W-1:0] band_reg;
    logic [DIST_W-1:0] last_reg;
    logic              valid_reg, valid_next;
    logic [OUT_W-1:0]  dist_reg;
    logic [DIST_W-1:0] delta;
    logic              fire;

    assign delta = (evt.dist_val >= last_reg) ? (evt.dist_val - last_reg)
                                              : (last_reg - evt.dist_val);

    // zero band behaves as one
    assign fire = evt.check && evt.sum_ok && (evt.dist_val < DIST_LIMIT)
                  && (delta != '0) && (delta >= band_reg);

    always_comb begin
        valid_next = valid_reg;
        if (fire) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            band_reg  <= BAND_W'(1);
            last_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (cfg_we) begin
                band_reg <= cfg_wdata;
            end
            if (fire) begin
                last_reg <= evt.dist_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            dist_reg <= evt.dist_val[OUT_W-1:0];
        end
    end

    assign m_valid    = valid_reg;
    assign m_distance = dist_reg;

    a_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        evt.check |-> !valid_reg)
        else $error("checksum transfer while result pending");

    a_last_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> (valid_reg && last_reg == {{(DIST_W-OUT_W){1'b0}}, dist_reg}))
        else $error("stored distance does not match report");

    a_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |-> (evt.dist_val < DIST_LIMIT))
        else $error("reported distance out of range");

endmodule
